// File: rtl/core/srr_pkg.sv
// Shared constants, codes and types of the selective-repeat receiver.
package srr_pkg;

  localparam int unsigned SeqW          = 4;
  localparam int unsigned SeqSpace      = 16;
  localparam int unsigned MaxWindow     = 8;
  localparam int unsigned DefaultWindow = 4;
  localparam int unsigned TagW          = 16;
  localparam int unsigned LenW          = 8;
  localparam int unsigned WinW          = 4;
  localparam int unsigned WalkW         = $clog2(MaxWindow);

  // Result kinds
  localparam logic KindAck = 1'b0;
  localparam logic KindDlv = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StAck,
    StDlv,
    StWait
  } srr_state_e;

  typedef struct packed {
    logic [TagW-1:0] tag;
    logic [LenW-1:0] length;
  } srr_slot_t;

  typedef struct packed {
    logic            en;
    logic [SeqW-1:0] addr;
    srr_slot_t       data;
  } srr_ram_wr_t;

  typedef struct packed {
    logic            kind;
    logic [SeqW-1:0] seq;
    logic [TagW-1:0] tag;
    logic [LenW-1:0] length;
    logic            last;
  } srr_res_t;

  typedef struct packed {
    logic     valid;
    srr_res_t res;
  } srr_push_t;

endpackage

// File: rtl/core/srr_pkt_if.sv
// Packet request channel: valid/ready handshake with the packet fields.
interface srr_pkt_if
  import srr_pkg::*;
;
  logic            valid;
  logic            ready;
  logic            pkt_is_data;
  logic            pkt_check_ok;
  logic [SeqW-1:0] pkt_seq;
  logic [TagW-1:0] pkt_tag;
  logic [LenW-1:0] pkt_length;

  modport source (
    output valid, pkt_is_data, pkt_check_ok, pkt_seq, pkt_tag, pkt_length,
    input  ready
  );

  modport sink (
    input  valid, pkt_is_data, pkt_check_ok, pkt_seq, pkt_tag, pkt_length,
    output ready
  );
endinterface

// File: rtl/core/srr_res_if.sv
// Result request channel: valid/ready handshake with acknowledgment/delivery fields.
interface srr_res_if
  import srr_pkg::*;
;
  logic            valid;
  logic            ready;
  logic            out_kind;
  logic [SeqW-1:0] out_seq;
  logic [TagW-1:0] out_tag;
  logic [LenW-1:0] out_length;
  logic            out_last;

  modport source (
    output valid, out_kind, out_seq, out_tag, out_length, out_last,
    input  ready
  );

  modport sink (
    input  valid, out_kind, out_seq, out_tag, out_length, out_last,
    output ready
  );
endinterface

// File: rtl/core/srr_slot_ram.sv
// Slot memory: tag and length per sequence number, one write and one registered read port.
module srr_slot_ram
  import srr_pkg::*;
(
  input  logic            clk_i,
  input  srr_ram_wr_t     wr_i,
  input  logic [SeqW-1:0] rd_addr_i,
  output srr_slot_t       rd_data_o
);

  srr_slot_t mem_q [SeqSpace];
  srr_slot_t rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/core/srr_out_reg.sv
// Output register: holds one result so the sequencer can move on while it waits.
module srr_out_reg
  import srr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  srr_push_t push_i,
  output logic      push_ready_o,
  srr_res_if.source res_o
);

  logic     valid_q;
  srr_res_t data_q;

  assign push_ready_o = !valid_q || res_o.ready;

  // Hold the result until taken, reload when free or draining
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i.valid && push_ready_o) begin
      valid_q <= 1'b1;
    end else if (res_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid && push_ready_o) begin
      data_q <= push_i.res;
    end
  end

  assign res_o.valid      = valid_q;
  assign res_o.out_kind   = data_q.kind;
  assign res_o.out_seq    = data_q.seq;
  assign res_o.out_tag    = data_q.tag;
  assign res_o.out_length = data_q.length;
  assign res_o.out_last   = data_q.last;

endmodule

// File: rtl/core/srr_ctrl.sv
// Receive sequencer: window check, valid map, expected number and in-order delivery walk.
module srr_ctrl
  import srr_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [WinW-1:0] window_i,
  srr_pkt_if.sink         pkt_i,
  output srr_ram_wr_t     ram_wr_o,
  output logic [SeqW-1:0] ram_rd_addr_o,
  input  srr_slot_t       ram_rd_data_i,
  output srr_push_t       push_o,
  input  logic            push_ready_i
);

  srr_state_e      state_q, state_d;
  logic [SeqW-1:0] exp_q, exp_d;
  logic [SeqSpace-1:0] valid_q, valid_d;
  logic [SeqW-1:0] ack_seq_q, ack_seq_d;
  logic            ack_last_q, ack_last_d;
  logic [WalkW-1:0] walk_q, walk_d;

  logic [WinW-1:0] win;
  logic [SeqW-1:0] seq_dist;
  logic [SeqW-1:0] prev_dist;
  logic            in_win;
  logic            in_prev;
  logic            good;
  logic [SeqW-1:0] exp_nx;
  logic            dlv_last;

  // Effective window: zero or out-of-range settings fall back to the default
  always_comb begin
    if (window_i == '0 || window_i > WinW'(MaxWindow)) begin
      win = WinW'(DefaultWindow);
    end else begin
      win = window_i;
    end
  end

  // Window checks on modular distance from the expected number
  assign seq_dist  = pkt_i.pkt_seq - exp_q;
  assign prev_dist = seq_dist + SeqW'(win);
  assign in_win    = {1'b0, seq_dist} < {1'b0, win};
  assign in_prev   = {1'b0, prev_dist} < {1'b0, win};
  assign good      = pkt_i.pkt_is_data && pkt_i.pkt_check_ok;
  assign exp_nx    = exp_q + 1'b1;
  assign dlv_last  = !valid_q[exp_nx] || (walk_q == WalkW'(MaxWindow - 1));

  assign pkt_i.ready   = (state_q == StIdle);
  assign ram_rd_addr_o = exp_q;

  // Next state and outputs
  always_comb begin
    state_d    = state_q;
    exp_d      = exp_q;
    valid_d    = valid_q;
    ack_seq_d  = ack_seq_q;
    ack_last_d = ack_last_q;
    walk_d     = walk_q;
    ram_wr_o   = '0;
    push_o     = '0;

    case (state_q)
      StIdle: begin
        if (pkt_i.valid && good && (in_win || in_prev)) begin
          ack_seq_d = pkt_i.pkt_seq;
          walk_d    = '0;
          state_d   = StAck;
          if (in_win) begin
            ack_last_d = !(valid_q[exp_q] || (pkt_i.pkt_seq == exp_q));
            // Store into an empty slot; a duplicate keeps the stored copy
            if (!valid_q[pkt_i.pkt_seq]) begin
              ram_wr_o.en          = 1'b1;
              ram_wr_o.addr        = pkt_i.pkt_seq;
              ram_wr_o.data.tag    = pkt_i.pkt_tag;
              ram_wr_o.data.length = pkt_i.pkt_length;
              valid_d[pkt_i.pkt_seq] = 1'b1;
            end
          end else begin
            ack_last_d = 1'b1;
          end
        end
      end
      StAck: begin
        push_o.valid      = 1'b1;
        push_o.res.kind   = KindAck;
        push_o.res.seq    = ack_seq_q;
        push_o.res.tag    = '0;
        push_o.res.length = '0;
        push_o.res.last   = ack_last_q;
        if (push_ready_i) begin
          state_d = ack_last_q ? StIdle : StDlv;
        end
      end
      StDlv: begin
        push_o.valid      = 1'b1;
        push_o.res.kind   = KindDlv;
        push_o.res.seq    = exp_q;
        push_o.res.tag    = ram_rd_data_i.tag;
        push_o.res.length = ram_rd_data_i.length;
        push_o.res.last   = dlv_last;
        // Release the slot and advance
        if (push_ready_i) begin
          valid_d[exp_q] = 1'b0;
          exp_d          = exp_nx;
          walk_d         = walk_q + 1'b1;
          state_d        = dlv_last ? StIdle : StWait;
        end
      end
      StWait: begin
        // Slot read of the new expected number lands next cycle
        state_d = StDlv;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      exp_q      <= '0;
      valid_q    <= '0;
      ack_seq_q  <= '0;
      ack_last_q <= 1'b0;
      walk_q     <= '0;
    end else begin
      state_q    <= state_d;
      exp_q      <= exp_d;
      valid_q    <= valid_d;
      ack_seq_q  <= ack_seq_d;
      ack_last_q <= ack_last_d;
      walk_q     <= walk_d;
    end
  end

`ifndef ASSERT_OFF
  a_dlv_slot_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDlv) |-> valid_q[exp_q])
    else $error("delivery from an empty slot");

  a_wait_slot_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWait) |-> valid_q[exp_q])
    else $error("walk continued onto an empty slot");

  a_exp_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDlv && push_ready_i) |=> (exp_q == SeqW'($past(exp_q) + 1'b1)))
    else $error("expected number did not advance after delivery");

  a_exp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle || state_q == StAck) |=> $stable(exp_q))
    else $error("expected number moved outside the delivery walk");
`endif

endmodule

// File: rtl/core/selective_repeat_receiver_core.sv
// Selective-repeat receiver core: config register, sequencer, slot memory, output register.
// Order: a taken packet moves the sequencer to its acknowledgment state, from which the
//   acknowledgment enters the output register once that register can take it. A dropped
//   packet leaves the sequencer idle. No new packet is taken until its last result is pushed;
//   output stalls hold the sequencer, and each further in-order delivery waits on the slot read.
// Reset: expected number 0, valid map cleared at once, window 4; slot memory is not cleared.
module selective_repeat_receiver_core
  import srr_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [WinW-1:0] cfg_wdata_i,
  srr_pkt_if.sink         pkt_i,
  srr_res_if.source       res_o
);

  logic [WinW-1:0] window_q;
  srr_ram_wr_t     ram_wr;
  logic [SeqW-1:0] ram_rd_addr;
  srr_slot_t       ram_rd_data;
  srr_push_t       push;
  logic            push_ready;

  // Window register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WinW'(DefaultWindow);
    end else if (cfg_we_i) begin
      window_q <= cfg_wdata_i;
    end
  end

  srr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .window_i      (window_q),
    .pkt_i         (pkt_i),
    .ram_wr_o      (ram_wr),
    .ram_rd_addr_o (ram_rd_addr),
    .ram_rd_data_i (ram_rd_data),
    .push_o        (push),
    .push_ready_i  (push_ready)
  );

  srr_slot_ram u_slot_ram (
    .clk_i     (clk_i),
    .wr_i      (ram_wr),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  srr_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .res_o        (res_o)
  );

endmodule

// File: dv/selective_repeat_receiver_core_tb.sv
// Self-checking testbench for the selective-repeat receiver core.
`timescale 1ns / 1ps

module selective_repeat_receiver_core_tb;
  import srr_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned MaxIdle      = 13;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned PhaseItems   = 33;
  localparam int unsigned NumPhases    = 12;

  typedef struct packed {
    logic            is_data;
    logic            check_ok;
    logic [SeqW-1:0] seq;
    logic [TagW-1:0] tag;
    logic [LenW-1:0] length;
  } pkt_item_t;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            cfg_we    = 1'b0;
  logic [WinW-1:0] cfg_wdata = '0;
  logic            pkt_valid = 1'b0;
  pkt_item_t       pkt_on_bus = '0;
  logic            res_ready = 1'b0;

  srr_pkt_if pkt_ch ();
  srr_res_if res_ch ();

  assign pkt_ch.valid        = pkt_valid;
  assign pkt_ch.pkt_is_data  = pkt_on_bus.is_data;
  assign pkt_ch.pkt_check_ok = pkt_on_bus.check_ok;
  assign pkt_ch.pkt_seq      = pkt_on_bus.seq;
  assign pkt_ch.pkt_tag      = pkt_on_bus.tag;
  assign pkt_ch.pkt_length   = pkt_on_bus.length;
  assign res_ch.ready        = res_ready;

  selective_repeat_receiver_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .pkt_i      (pkt_ch.sink),
    .res_o      (res_ch.source)
  );

  always #6 clk = ~clk;

  // Receiver state as the checker sees it
  logic [WinW-1:0] m_window = WinW'(DefaultWindow);
  int unsigned     m_next_seq = 0;
  logic            m_slot_full [SeqSpace];
  logic [TagW-1:0] m_slot_tag  [SeqSpace];
  logic [LenW-1:0] m_slot_len  [SeqSpace];

  pkt_item_t   pending_pkts [$];
  srr_res_t    acks_dlvs_due [$];
  int unsigned pkts_queued = 0;
  int unsigned pkts_taken  = 0;
  int unsigned acks_seen   = 0;
  int unsigned dlvs_seen   = 0;
  int unsigned error_cnt   = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned windows_set = 0;

  bit          pkt_taken = 1'b0;
  bit          res_taken = 1'b0;
  bit          hold_off  = 1'b0;
  bit          pkt_calm  = 1'b0;
  bit          res_calm  = 1'b0;
  int unsigned pkt_gap   = 0;
  int unsigned res_wait  = 0;

  logic [WinW-1:0] window_plan [NumPhases] = '{
    4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd9, 4'd5, 4'd8, 4'd2, 4'd4, 4'd7, 4'd6
  };

  initial begin
    for (int i = 0; i < SeqSpace; i++) m_slot_full[i] = 1'b0;
  end

  task automatic flag_error(string msg);
    error_cnt++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Zero or an out-of-range value falls back to the default window
  function automatic int unsigned window_eff(logic [WinW-1:0] w);
    if (w == 0 || w > MaxWindow) return DefaultWindow;
    return int'(w);
  endfunction

  function automatic bit seq_within(int unsigned base, int unsigned seq, int unsigned w);
    return ((seq + SeqSpace - base) % SeqSpace) < w;
  endfunction

  // Work out the acknowledgment and deliveries one accepted packet causes
  function automatic void receive_packet(pkt_item_t p);
    srr_res_t    outs [MaxWindow+1];
    int unsigned n;
    int unsigned w;
    int unsigned prev_base;
    int unsigned walked;
    n = 0;
    if (!p.is_data || !p.check_ok) return;
    w = window_eff(m_window);
    prev_base = (m_next_seq + SeqSpace - w) % SeqSpace;
    if (seq_within(m_next_seq, p.seq, w)) begin
      outs[n] = '{kind: KindAck, seq: p.seq, tag: '0, length: '0, last: 1'b0};
      n++;
      // keep the first copy of a duplicate
      if (!m_slot_full[p.seq]) begin
        m_slot_tag[p.seq]  = p.tag;
        m_slot_len[p.seq]  = p.length;
        m_slot_full[p.seq] = 1'b1;
      end
      // drain consecutive filled slots in order
      walked = 0;
      while (walked < MaxWindow && m_slot_full[m_next_seq]) begin
        outs[n] = '{kind: KindDlv, seq: SeqW'(m_next_seq), tag: m_slot_tag[m_next_seq],
                    length: m_slot_len[m_next_seq], last: 1'b0};
        n++;
        m_slot_full[m_next_seq] = 1'b0;
        m_next_seq = (m_next_seq + 1) % SeqSpace;
        walked++;
      end
    end else if (seq_within(prev_base, p.seq, w)) begin
      outs[n] = '{kind: KindAck, seq: p.seq, tag: '0, length: '0, last: 1'b0};
      n++;
    end
    if (n != 0) outs[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) acks_dlvs_due.push_back(outs[i]);
  endfunction

  function automatic void queue_pkt(logic is_data, logic ok, logic [SeqW-1:0] seq,
                                    logic [TagW-1:0] tag, logic [LenW-1:0] length);
    pending_pkts.push_back('{is_data: is_data, check_ok: ok, seq: seq, tag: tag,
                             length: length});
    pkts_queued++;
  endfunction

  function automatic logic [TagW-1:0] rand_tag();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return TagW'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [LenW-1:0] rand_len();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return LenW'($urandom_range(0, 255));
    endcase
  endfunction

  // Write the window register while the block is idle
  task automatic set_window(logic [WinW-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    m_window   = value;
    windows_set++;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Wait until every packet is taken and every result has come back
  task automatic wait_idle();
    do @(negedge clk);
    while (pkts_taken != pkts_queued || acks_dlvs_due.size() != 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Fill shuffled windows from the current base, with noise and retransmissions mixed in
  task automatic gen_phase(int unsigned goal);
    logic [SeqW-1:0] round [MaxWindow];
    logic [SeqW-1:0] swap;
    int unsigned     w;
    int unsigned     base;
    int unsigned     made;
    int unsigned     j;
    w    = window_eff(m_window);
    base = m_next_seq;
    made = 0;
    while (made < goal) begin
      for (int k = 0; k < w; k++) round[k] = SeqW'((base + k) % SeqSpace);
      for (int k = w - 1; k > 0; k--) begin
        j        = $urandom_range(0, k);
        swap     = round[k];
        round[k] = round[j];
        round[j] = swap;
      end
      for (int k = 0; k < w && made < goal; k++) begin
        case ($urandom_range(0, 11))
          0: queue_pkt(1'b0, 1'($urandom_range(0, 1)), SeqW'($urandom_range(0, 15)),
                       rand_tag(), rand_len());
          1: queue_pkt(1'b1, 1'b0, round[k], rand_tag(), rand_len());
          2: begin
            queue_pkt(1'b1, 1'b1,
                      SeqW'((base + SeqSpace - 1 - $urandom_range(0, w - 1)) % SeqSpace),
                      rand_tag(), rand_len());
            made++;
          end
          3: begin
            queue_pkt(1'b1, 1'b1, SeqW'($urandom_range(0, 15)), rand_tag(), rand_len());
            made++;
          end
          4: if (k > 0) begin
            queue_pkt(1'b1, 1'b1, round[$urandom_range(0, k - 1)], rand_tag(), rand_len());
            made++;
          end
          default: ;
        endcase
        queue_pkt(1'b1, 1'b1, round[k], rand_tag(), rand_len());
        made++;
      end
      base = (base + w) % SeqSpace;
    end
  endtask

  // Sample both channels: check results first, then predict for the new request
  always @(posedge clk) begin : sample
    srr_res_t want;
    cycle_cnt++;
    res_taken = res_ch.valid && res_ready;
    if (res_taken) begin
      if (acks_dlvs_due.size() == 0) begin
        flag_error($sformatf("unexpected result kind %0d seq %0d tag %h len %h last %0d",
                             res_ch.out_kind, res_ch.out_seq, res_ch.out_tag,
                             res_ch.out_length, res_ch.out_last));
      end else begin
        want = acks_dlvs_due.pop_front();
        if (res_ch.out_kind !== want.kind || res_ch.out_seq !== want.seq ||
            res_ch.out_tag !== want.tag || res_ch.out_length !== want.length ||
            res_ch.out_last !== want.last) begin
          flag_error($sformatf(
              "result got kind %0d seq %0d tag %h len %h last %0d, want %0d %0d %h %h %0d",
              res_ch.out_kind, res_ch.out_seq, res_ch.out_tag, res_ch.out_length,
              res_ch.out_last, want.kind, want.seq, want.tag, want.length, want.last));
        end
        if (want.kind == KindAck) acks_seen++;
        else dlvs_seen++;
      end
    end
    pkt_taken = pkt_valid && pkt_ch.ready;
    if (pkt_taken) begin
      pkts_taken++;
      receive_packet(pkt_on_bus);
    end
  end

  // Drive packets from the pending queue with a random gap after each one
  always @(negedge clk) begin : drive_pkts
    pkt_item_t p;
    if (!pkt_valid || pkt_taken) begin
      if (pkt_gap != 0) begin
        pkt_valid <= 1'b0;
        pkt_gap--;
      end else if (rst_n && pending_pkts.size() != 0) begin
        p = pending_pkts.pop_front();
        pkt_on_bus <= p;
        pkt_valid  <= 1'b1;
        if ($urandom_range(0, 19) == 0) pkt_calm = !pkt_calm;
        pkt_gap = pkt_calm ? 0 : $urandom_range(0, MaxIdle);
      end else begin
        pkt_valid <= 1'b0;
      end
    end
  end

  // Stall the result side at random; hold it fully low during the long hold-off
  always @(negedge clk) begin
    if (res_taken) begin
      if ($urandom_range(0, 19) == 0) res_calm = !res_calm;
      res_wait = res_calm ? 0 : $urandom_range(0, MaxIdle);
    end
    if (hold_off || res_wait != 0) begin
      res_ready <= 1'b0;
      if (res_wait != 0) res_wait--;
    end else begin
      res_ready <= rst_n;
    end
  end

  // Block the result side for a long stretch so the input backs up
  initial begin : long_hold
    int unsigned n;
    wait (pkts_taken >= 150);
    @(posedge clk);
    hold_off = 1'b1;
    for (n = 0; n < HoldCycles; n++) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin : watchdog
    while (cycle_cnt < CycleLimit) @(posedge clk);
    $display("TIMEOUT after %0d cycles, %0d results outstanding, %0d of %0d packets taken",
             cycle_cnt, acks_dlvs_due.size(), pkts_taken, pkts_queued);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Default window after reset: drops, reordering, duplicates, old window, out of window
    queue_pkt(1'b0, 1'b1, 4'd0, 16'hFFFF, 8'hFF);
    queue_pkt(1'b1, 1'b0, 4'd0, 16'hFFFF, 8'hFF);
    queue_pkt(1'b0, 1'b0, 4'd0, 16'h0000, 8'h00);
    queue_pkt(1'b1, 1'b1, 4'd2, 16'h0000, 8'h00);
    queue_pkt(1'b1, 1'b1, 4'd1, 16'hFFFF, 8'hFF);
    queue_pkt(1'b1, 1'b1, 4'd1, 16'h1234, 8'h5A);
    queue_pkt(1'b1, 1'b1, 4'd0, 16'hA5A5, 8'h80);
    queue_pkt(1'b1, 1'b1, 4'd3, 16'h5A5A, 8'h7F);
    queue_pkt(1'b1, 1'b1, 4'd3, 16'h0F0F, 8'h01);
    queue_pkt(1'b1, 1'b1, 4'd0, 16'hF0F0, 8'hFE);
    queue_pkt(1'b1, 1'b1, 4'd15, 16'h1111, 8'h11);
    queue_pkt(1'b1, 1'b1, 4'd8, 16'h2222, 8'h22);
    queue_pkt(1'b1, 1'b1, 4'd7, 16'h7777, 8'h77);
    queue_pkt(1'b1, 1'b1, 4'd6, 16'h6666, 8'h66);
    queue_pkt(1'b1, 1'b1, 4'd5, 16'h5555, 8'h55);
    queue_pkt(1'b1, 1'b1, 4'd4, 16'h4444, 8'h44);
    wait_idle();

    // Widest window: fill from the top down so one packet releases the whole window
    set_window(WinW'(MaxWindow));
    for (int s = 15; s >= 8; s--) queue_pkt(1'b1, 1'b1, SeqW'(s), TagW'(16'hC000 + s), LenW'(s));
    queue_pkt(1'b1, 1'b1, 4'd8, 16'hBEEF, 8'hEE);
    wait_idle();

    // Random phases across window settings, including zero and out-of-range values
    for (int ph = 0; ph < NumPhases; ph++) begin
      set_window(window_plan[ph]);
      gen_phase(PhaseItems);
      wait_idle();
    end

    $display("Run covered %0d packets, %0d acknowledgments and %0d in-order deliveries",
             pkts_taken, acks_seen, dlvs_seen);
    $display("over %0d window settings, with random stalls and one long output hold-off",
             windows_set);
    if (error_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
